// ===== hdl/edg_pkg.sv =====
// edg_pkg: shared types and codes of the lift group dispatcher
// depends on nothing; used by the interfaces, edg_rival and the top level
`default_nettype none

package edg_pkg;

  // fixed field widths of the request, action and configuration ports
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned LIFT_W     = 2;
  localparam int unsigned FLOOR_W    = 4;
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLOORS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFTS  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_HALL_UP   = 2'd0,
    KIND_HALL_DOWN = 2'd1,
    KIND_CAR       = 2'd2,
    KIND_DECIDE    = 2'd3
  } kind_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_STAY      = 3'd0,
    ACT_UP        = 3'd1,
    ACT_DOWN      = 3'd2,
    ACT_OPEN_UP   = 3'd3,
    ACT_OPEN_DOWN = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACT_START,
    ST_SCAN,
    ST_EMIT,
    ST_SWEEP
  } state_e;

  // blocking verdict of one competing lift for the up and the down call
  typedef struct packed {
    logic blk_up;
    logic blk_dn;
  } rival_t;

endpackage

`default_nettype wire

// ===== hdl/edg_req_if.sv =====
// edg_req_if: request channel carrying call and decide events
// depends on edg_pkg
`default_nettype none

interface edg_req_if;
  import edg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [LIFT_W-1:0]    lift;
  logic [FLOOR_W-1:0]   floor;

  modport source (output valid, kind, lift, floor, input ready);
  modport sink   (input valid, kind, lift, floor, output ready);
endinterface

`default_nettype wire

// ===== hdl/edg_act_if.sv =====
// edg_act_if: result channel carrying one lift action per transfer
// depends on edg_pkg
`default_nettype none

interface edg_act_if;
  import edg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [LIFT_W-1:0]    lift_index;
  logic [ACTION_W-1:0]  action;
  logic                 last;

  modport source (output valid, lift_index, action, last, input ready);
  modport sink   (input valid, lift_index, action, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/edg_rival.sv =====
// edg_rival: shared compare unit, judges whether one lift beats the scanning lift
// to a hall call; depends on edg_pkg
`default_nettype none

module edg_rival import edg_pkg::*; #(
  parameter int unsigned FW = 4
) (
  input  logic [FW-1:0] call_floor_i,
  input  logic [FW-1:0] my_dist_i,
  input  logic [FW-1:0] rival_floor_i,
  input  dir_e          rival_dir_i,
  input  logic          rival_valid_i,
  input  logic          rival_lower_i,
  output rival_t        rival_o
);

  logic [FW-1:0] gap;
  logic          closer;
  logic          up_rival;
  logic          dn_rival;

  // distance of the other lift to the call and whether it wins
  always_comb begin
    gap = (call_floor_i > rival_floor_i) ? (call_floor_i - rival_floor_i)
                                         : (rival_floor_i - call_floor_i);
    closer = (gap < my_dist_i) || ((gap == my_dist_i) && rival_lower_i);
    up_rival = (rival_dir_i == DIR_IDLE) ||
               ((rival_dir_i == DIR_UP) && (rival_floor_i <= call_floor_i));
    dn_rival = (rival_dir_i == DIR_IDLE) ||
               ((rival_dir_i == DIR_DOWN) && (call_floor_i <= rival_floor_i));
    rival_o.blk_up = rival_valid_i && up_rival && closer;
    rival_o.blk_dn = rival_valid_i && dn_rival && closer;
  end

endmodule

`default_nettype wire

// ===== hdl/elevator_group_dispatcher.sv =====
// elevator_group_dispatcher: top level of the lift group dispatcher
// depends on edg_pkg, edg_req_if, edg_act_if and edg_rival
//
// Call and car-button requests record the call, then run a sweep over every
// lift that clamps floors, masks calls and recomputes each lift's direction.
// A decide request runs one sequencer over the lifts in use: a moving lift or
// an idle lift with a call at its own floor gets its action at once; any other
// idle lift then scans the floors in use, passing over each floor without a
// hall call or at its own floor and stepping through each lift in use at each
// other floor with one, through a single shared rival compare unit, and then
// picks its move. The actions are then handed out one per cycle while the
// output register drains, and the direction sweep follows. A write of
// floors_in_use starts the same sweep, during which no request is taken.
`default_nettype none

module elevator_group_dispatcher import edg_pkg::*; #(
  parameter int unsigned MAX_FLOORS = 16,
  parameter int unsigned MAX_LIFTS  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  edg_req_if.sink               req_i,
  edg_act_if.source             act_o
);

  localparam int unsigned FW  = $clog2(MAX_FLOORS);
  localparam int unsigned NFW = $clog2(MAX_FLOORS + 1);
  localparam int unsigned LW  = (MAX_LIFTS > 1) ? $clog2(MAX_LIFTS) : 1;
  localparam int unsigned NLW = $clog2(MAX_LIFTS + 1);
  localparam int unsigned CFW = (NFW > CFG_DATA_W) ? NFW : CFG_DATA_W;
  localparam int unsigned CLW = (NLW > CFG_DATA_W) ? NLW : CFG_DATA_W;

  // configuration
  logic [NFW-1:0]        floors_q, floors_d;
  logic [NLW-1:0]        lifts_q, lifts_d;

  // lift and call state
  logic [FW-1:0]         car_floor_q [MAX_LIFTS];
  logic [FW-1:0]         car_floor_d [MAX_LIFTS];
  dir_e                  car_dir_q [MAX_LIFTS];
  dir_e                  car_dir_d [MAX_LIFTS];
  logic [MAX_FLOORS-1:0] car_calls_q [MAX_LIFTS];
  logic [MAX_FLOORS-1:0] car_calls_d [MAX_LIFTS];
  logic [MAX_FLOORS-1:0] hall_up_q, hall_up_d;
  logic [MAX_FLOORS-1:0] hall_dn_q, hall_dn_d;
  action_e               acts_q [MAX_LIFTS];
  action_e               acts_d [MAX_LIFTS];

  // sequencer
  state_e                state_q, state_d;
  logic [NLW-1:0]        idx_q, idx_d;
  logic [NLW-1:0]        me_q, me_d;
  logic [NFW-1:0]        f_q, f_d;
  logic [FW-1:0]         pos_q, pos_d;
  logic                  blk_up_q, blk_up_d;
  logic                  blk_dn_q, blk_dn_d;
  logic                  have_below_q, have_below_d;
  logic                  have_above_q, have_above_d;
  logic [FW-1:0]         below_q, below_d;
  logic [FW-1:0]         above_q, above_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [LIFT_W-1:0]     out_lift_q, out_lift_d;
  action_e               out_act_q, out_act_d;
  logic                  out_last_q, out_last_d;

  // shared unit and read port at idx_q
  logic [LW-1:0]         rd;
  logic [FW-1:0]         cur_floor;
  dir_e                  cur_dir;
  logic [MAX_FLOORS-1:0] cur_calls;
  logic [FW-1:0]         scan_fl;
  logic [FW-1:0]         my_dist;
  rival_t                rival;

  assign rd        = idx_q[LW-1:0];
  assign cur_floor = car_floor_q[rd];
  assign cur_dir   = car_dir_q[rd];
  assign cur_calls = car_calls_q[rd];
  assign scan_fl   = f_q[FW-1:0];
  assign my_dist   = (scan_fl > pos_q) ? (scan_fl - pos_q) : (pos_q - scan_fl);

  edg_rival #(.FW(FW)) u_rival (
    .call_floor_i  (scan_fl),
    .my_dist_i     (my_dist),
    .rival_floor_i (cur_floor),
    .rival_dir_i   (cur_dir),
    .rival_valid_i (idx_q != me_q),
    .rival_lower_i (idx_q < me_q),
    .rival_o       (rival)
  );

  // ports
  logic req_fire;
  logic act_fire;
  assign req_i.ready      = (state_q == ST_IDLE) && !cfg_we_i;
  assign req_fire         = req_i.valid && req_i.ready;
  assign act_o.valid      = out_valid_q;
  assign act_o.lift_index = out_lift_q;
  assign act_o.action     = out_act_q;
  assign act_o.last       = out_last_q;
  assign act_fire         = out_valid_q && act_o.ready;

  // next state and datapath
  always_comb begin
    logic [CFW-1:0]        fv;
    logic [CLW-1:0]        lv;
    logic [FW-1:0]         ev_floor;
    action_e               act;
    logic                  decided;
    logic                  at_top;
    logic                  bu, bd, ok;
    logic [FW-1:0]         d;
    logic [NLW-1:0]        me_next;
    logic [MAX_FLOORS-1:0] fmask;
    logic [MAX_FLOORS-1:0] amask;
    logic [MAX_FLOORS-1:0] calls_n;
    logic [FW-1:0]         floor_n;
    logic                  last;

    floors_d     = floors_q;
    lifts_d      = lifts_q;
    car_floor_d  = car_floor_q;
    car_dir_d    = car_dir_q;
    car_calls_d  = car_calls_q;
    hall_up_d    = hall_up_q;
    hall_dn_d    = hall_dn_q;
    acts_d       = acts_q;
    state_d      = state_q;
    idx_d        = idx_q;
    me_d         = me_q;
    f_d          = f_q;
    pos_d        = pos_q;
    blk_up_d     = blk_up_q;
    blk_dn_d     = blk_dn_q;
    have_below_d = have_below_q;
    have_above_d = have_above_q;
    below_d      = below_q;
    above_d      = above_q;
    out_valid_d  = out_valid_q && !act_fire;
    out_lift_d   = out_lift_q;
    out_act_d    = out_act_q;
    out_last_d   = out_last_q;

    fv       = CFW'(cfg_data_i);
    lv       = CLW'(cfg_data_i[2:0]);
    ev_floor = FW'(req_i.floor);
    act      = ACT_STAY;
    decided  = 1'b1;
    at_top   = 1'b0;
    bu       = 1'b0;
    bd       = 1'b0;
    ok       = 1'b0;
    d        = '0;
    me_next  = me_q + NLW'(1);
    last     = 1'b0;
    for (int i = 0; i < MAX_FLOORS; i++) begin
      fmask[i] = (i < int'(floors_q));
    end
    calls_n = cur_calls & fmask;
    floor_n = (NFW'(cur_floor) >= floors_q) ? FW'(floors_q - NFW'(1)) : cur_floor;
    for (int i = 0; i < MAX_FLOORS; i++) begin
      amask[i] = (i > int'(floor_n));
    end

    case (state_q)
      // wait for a request
      ST_IDLE: begin
        if (req_fire) begin
          if (kind_e'(req_i.kind) == KIND_DECIDE) begin
            state_d = ST_ACT_START;
            idx_d   = '0;
            me_d    = '0;
          end else begin
            if (NFW'(req_i.floor) < floors_q) begin
              case (kind_e'(req_i.kind))
                KIND_HALL_UP:   hall_up_d[ev_floor] = 1'b1;
                KIND_HALL_DOWN: hall_dn_d[ev_floor] = 1'b1;
                default: begin
                  if (NLW'(req_i.lift) < lifts_q) begin
                    car_calls_d[LW'(req_i.lift)][ev_floor] = 1'b1;
                  end
                end
              endcase
            end
            state_d = ST_SWEEP;
            idx_d   = '0;
          end
        end
      end

      // action of a moving lift or an idle lift with a call at its floor
      ST_ACT_START: begin
        at_top = (NFW'(cur_floor) + NFW'(1)) == floors_q;
        case (cur_dir)
          DIR_UP: begin
            if (hall_up_q[cur_floor]) act = ACT_OPEN_UP;
            else if (cur_calls[cur_floor]) act = at_top ? ACT_OPEN_DOWN : ACT_OPEN_UP;
            else act = ACT_UP;
          end
          DIR_DOWN: begin
            if (hall_dn_q[cur_floor]) act = ACT_OPEN_DOWN;
            else if (cur_calls[cur_floor]) act = (cur_floor == '0) ? ACT_OPEN_UP
                                                                  : ACT_OPEN_DOWN;
            else act = ACT_DOWN;
          end
          default: begin
            if (hall_dn_q[cur_floor]) act = ACT_OPEN_DOWN;
            else if (hall_up_q[cur_floor]) act = ACT_OPEN_UP;
            else decided = 1'b0;
          end
        endcase
        if (decided) begin
          acts_d[me_q[LW-1:0]] = act;
          me_d  = me_next;
          idx_d = (me_next == lifts_q) ? '0 : me_next;
          if (me_next == lifts_q) state_d = ST_EMIT;
        end else begin
          state_d      = ST_SCAN;
          pos_d        = cur_floor;
          f_d          = '0;
          idx_d        = '0;
          blk_up_d     = 1'b0;
          blk_dn_d     = 1'b0;
          have_below_d = 1'b0;
          have_above_d = 1'b0;
        end
      end

      // idle lift walks the floors, one rival per cycle at a floor with a call
      ST_SCAN: begin
        if (f_q == floors_q) begin
          if (!have_below_q && !have_above_q) act = ACT_STAY;
          else if (have_below_q && (!have_above_q || below_q <= above_q)) act = ACT_DOWN;
          else act = ACT_UP;
          acts_d[me_q[LW-1:0]] = act;
          me_d    = me_next;
          idx_d   = (me_next == lifts_q) ? '0 : me_next;
          state_d = (me_next == lifts_q) ? ST_EMIT : ST_ACT_START;
        end else if (!(hall_up_q[scan_fl] || hall_dn_q[scan_fl]) || scan_fl == pos_q) begin
          f_d = f_q + NFW'(1);
        end else begin
          bu = blk_up_q | rival.blk_up;
          bd = blk_dn_q | rival.blk_dn;
          if (idx_q + NLW'(1) == lifts_q) begin
            ok = (hall_up_q[scan_fl] && !bu) || (hall_dn_q[scan_fl] && !bd);
            d  = my_dist;
            if (ok) begin
              if (scan_fl < pos_q) begin
                if (!have_below_q || d < below_q) begin
                  have_below_d = 1'b1;
                  below_d      = d;
                end
              end else begin
                if (!have_above_q || d < above_q) begin
                  have_above_d = 1'b1;
                  above_d      = d;
                end
              end
            end
            f_d      = f_q + NFW'(1);
            idx_d    = '0;
            blk_up_d = 1'b0;
            blk_dn_d = 1'b0;
          end else begin
            idx_d    = idx_q + NLW'(1);
            blk_up_d = bu;
            blk_dn_d = bd;
          end
        end
      end

      // hand out one action and apply it
      ST_EMIT: begin
        if (!out_valid_q || act_fire) begin
          act         = acts_q[rd];
          last        = (idx_q + NLW'(1)) == lifts_q;
          out_valid_d = 1'b1;
          out_lift_d  = LIFT_W'(idx_q);
          out_act_d   = act;
          out_last_d  = last;
          case (act)
            ACT_UP: begin
              if ((NFW'(cur_floor) + NFW'(1)) < floors_q) begin
                car_floor_d[rd] = cur_floor + FW'(1);
              end
            end
            ACT_DOWN: begin
              if (cur_floor != '0) car_floor_d[rd] = cur_floor - FW'(1);
            end
            ACT_OPEN_UP: begin
              hall_up_d[cur_floor]      = 1'b0;
              car_calls_d[rd][cur_floor] = 1'b0;
            end
            ACT_OPEN_DOWN: begin
              hall_dn_d[cur_floor]      = 1'b0;
              car_calls_d[rd][cur_floor] = 1'b0;
            end
            default: ;
          endcase
          if (last) begin
            state_d = ST_SWEEP;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + NLW'(1);
          end
        end
      end

      // clamp, mask and recompute direction, one lift per cycle
      ST_SWEEP: begin
        hall_up_d        = hall_up_q & fmask;
        hall_dn_d        = hall_dn_q & fmask;
        car_calls_d[rd]  = calls_n;
        car_floor_d[rd]  = floor_n;
        if (calls_n == '0) car_dir_d[rd] = DIR_IDLE;
        else if ((calls_n & amask) != '0) car_dir_d[rd] = DIR_UP;
        else car_dir_d[rd] = DIR_DOWN;
        if (idx_q == NLW'(MAX_LIFTS - 1)) state_d = ST_IDLE;
        else idx_d = idx_q + NLW'(1);
      end

      default: state_d = ST_IDLE;
    endcase

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLOORS: begin
          if (fv < CFW'(2)) floors_d = NFW'(2);
          else if (fv > CFW'(MAX_FLOORS)) floors_d = NFW'(MAX_FLOORS);
          else floors_d = NFW'(fv);
          state_d = ST_SWEEP;
          idx_d   = '0;
        end
        CFG_LIFTS: begin
          if (lv < CLW'(1)) lifts_d = NLW'(1);
          else if (lv > CLW'(MAX_LIFTS)) lifts_d = NLW'(MAX_LIFTS);
          else lifts_d = NLW'(lv);
        end
        default: ;
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floors_q    <= (MAX_FLOORS < 16) ? NFW'(MAX_FLOORS) : NFW'(16);
      lifts_q     <= (MAX_LIFTS < 4) ? NLW'(MAX_LIFTS) : NLW'(4);
      hall_up_q   <= '0;
      hall_dn_q   <= '0;
      for (int l = 0; l < MAX_LIFTS; l++) begin
        car_floor_q[l] <= '0;
        car_dir_q[l]   <= DIR_IDLE;
        car_calls_q[l] <= '0;
      end
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      me_q        <= '0;
      f_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      floors_q    <= floors_d;
      lifts_q     <= lifts_d;
      hall_up_q   <= hall_up_d;
      hall_dn_q   <= hall_dn_d;
      car_floor_q <= car_floor_d;
      car_dir_q   <= car_dir_d;
      car_calls_q <= car_calls_d;
      state_q     <= state_d;
      idx_q       <= idx_d;
      me_q        <= me_d;
      f_q         <= f_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk_i) begin
    acts_q       <= acts_d;
    pos_q        <= pos_d;
    blk_up_q     <= blk_up_d;
    blk_dn_q     <= blk_dn_d;
    have_below_q <= have_below_d;
    have_above_q <= have_above_d;
    below_q      <= below_d;
    above_q      <= above_d;
    out_lift_q   <= out_lift_d;
    out_act_q    <= out_act_d;
    out_last_q   <= out_last_d;
  end

endmodule

`default_nettype wire
